// ===== hdl/segmented_ring_slot_allocator_assert.svh =====
// Assertion macros used by the srsa_alloc module.
// Each takes a label, the clock, the active-low reset, a condition and an expected
// property, and reports a message string on failure.
`ifndef SEGMENTED_RING_SLOT_ALLOCATOR_ASSERT_SVH
`define SEGMENTED_RING_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SRSA_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SRSA_ASSERT_NXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/srsa_pkg.sv =====
`default_nettype none

package srsa_pkg;

  localparam int SEG_SLOTS   = 64;
  localparam int MAX_SEGS    = 4;
  localparam int TOTAL_SLOTS = SEG_SLOTS * MAX_SEGS;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
  localparam int HEAD_W      = $clog2(TOTAL_SLOTS + 1);
  localparam int SEG_W       = $clog2(MAX_SEGS + 1);

  typedef enum logic {
    FUNC_ALLOC  = 1'b0,
    FUNC_RETIRE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_GROW    = 2'd1,
    ST_BAD_RETIRE = 2'd2
  } status_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] retire_slot;
  } req_t;

  typedef struct packed {
    logic [7:0] slot;
    logic       grew;
    status_t    status;
    logic [2:0] segments_in_use;
  } rsp_t;

  // Single write into the live-bit store.
  typedef struct packed {
    logic              en;
    logic              set;
    logic [SLOT_W-1:0] idx;
  } live_upd_t;

endpackage

`default_nettype wire

// ===== hdl/srsa_live_bits.sv =====
`default_nettype none

module srsa_live_bits
  import srsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] head_idx,
  input  wire logic [SLOT_W-1:0] ret_idx,
  input  wire live_upd_t         upd,
  output logic                   head_live,
  output logic                   ret_live
);

  logic [TOTAL_SLOTS-1:0] live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (upd.en) begin
      live_r[upd.idx] <= upd.set;
    end
  end

  assign head_live = live_r[head_idx];
  assign ret_live  = live_r[ret_idx];

endmodule

`default_nettype wire

// ===== hdl/srsa_alloc.sv =====
`default_nettype none

`include "segmented_ring_slot_allocator_assert.svh"

module srsa_alloc
  import srsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire req_t              req,
  input  wire logic              head_live,
  input  wire logic              ret_live,
  output logic [SLOT_W-1:0]      head_idx,
  output live_upd_t              upd,
  output rsp_t                   rsp
);

  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [SEG_W-1:0]  seg_cnt_r, seg_nxt;
  logic [HEAD_W-1:0] cap;
  logic [HEAD_W-1:0] head_w;
  logic [HEAD_W-1:0] slot_full;
  logic              need_grow;
  logic              seg_full;
  logic              ret_in_range;

  assign cap          = HEAD_W'(seg_cnt_r) * HEAD_W'(SEG_SLOTS);
  // wrap the head once it reaches the capacity in use
  assign head_w       = (head_r >= cap) ? '0 : head_r;
  assign head_idx     = head_w[SLOT_W-1:0];
  assign need_grow    = (seg_cnt_r == '0) || head_live;
  assign seg_full     = seg_cnt_r >= SEG_W'(MAX_SEGS);
  assign ret_in_range = HEAD_W'(req.retire_slot) < cap;
  assign slot_full    = need_grow ? cap : head_w;

  always_comb begin
    head_nxt   = head_r;
    seg_nxt    = seg_cnt_r;
    upd        = '0;
    rsp.slot   = '0;
    rsp.grew   = 1'b0;
    rsp.status = ST_OK;
    if (req.func == FUNC_RETIRE) begin
      rsp.slot = req.retire_slot;
      if (ret_in_range && ret_live) begin
        upd.en  = 1'b1;
        upd.set = 1'b0;
        upd.idx = req.retire_slot;
      end else begin
        rsp.status = ST_BAD_RETIRE;
      end
    end else begin
      head_nxt = head_w;
      if (need_grow && seg_full) begin
        rsp.status = ST_NO_GROW;
      end else begin
        if (need_grow) begin
          seg_nxt  = seg_cnt_r + SEG_W'(1);
          rsp.grew = 1'b1;
        end
        upd.en   = 1'b1;
        upd.set  = 1'b1;
        upd.idx  = slot_full[SLOT_W-1:0];
        rsp.slot = slot_full[SLOT_W-1:0];
        head_nxt = slot_full + HEAD_W'(1);
      end
    end
    rsp.segments_in_use = seg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      seg_cnt_r <= '0;
    end else if (step) begin
      head_r    <= head_nxt;
      seg_cnt_r <= seg_nxt;
    end
  end

  `SRSA_ASSERT_NOW(a_seg_bound, clk, rst_n, 1'b1, seg_cnt_r <= SEG_W'(MAX_SEGS), "segment count past maximum")
  `SRSA_ASSERT_NOW(a_head_bound, clk, rst_n, 1'b1, head_r <= cap, "head beyond capacity in use")
  `SRSA_ASSERT_NXT(a_grow_count, clk, rst_n, step && rsp.grew, seg_cnt_r == $past(seg_cnt_r) + SEG_W'(1), "growth did not add one segment")
  `SRSA_ASSERT_NXT(a_refuse_hold, clk, rst_n, step && (rsp.status == ST_NO_GROW), $stable(seg_cnt_r), "refused allocate changed segment count")

endmodule

`default_nettype wire

// ===== hdl/segmented_ring_slot_allocator.sv =====
// Segmented ring slot allocator.
// Input channel in_valid/in_ready/in_data carries one request: allocate a slot, or
// retire the slot given in retire_slot. Output channel out_valid/out_ready/out_data
// returns exactly one result per request, in order: the slot, a grew flag, a status
// (ok, no segment left to grow, bad retire) and the number of enabled segments.
// A request is captured in an input register; once the result register is free or being
// read, one pass of logic checks the live bit at the head (or at the retired slot),
// updates head, segment count and live bits, and loads the result register. Throughput
// is one request per cycle while out_ready stays high, set by the live-bit read and head
// update that each request depends on.
// A new request is taken while a result waits, as long as the input register can hand
// its item on. When out_ready stays low both registers fill and in_ready drops; nothing
// is lost or repeated.
// Reset (rst_n low, synchronous) clears all live bits, the head and the segment count
// at once, and empties both registers; no clearing pass is needed.
`default_nettype none

module segmented_ring_slot_allocator
  import srsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  logic              in_full_r;
  req_t              req_r;
  logic              out_valid_r;
  rsp_t              rsp_r;
  logic              advance;
  logic [SLOT_W-1:0] head_idx;
  logic              head_live;
  logic              ret_live;
  live_upd_t         upd;
  live_upd_t         upd_gated;
  rsp_t              rsp;

  assign advance   = in_full_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_full_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  // commit live-bit writes only when the item actually moves on
  always_comb begin
    upd_gated    = upd;
    upd_gated.en = upd.en && advance;
  end

  srsa_live_bits u_live (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_idx  (head_idx),
    .ret_idx   (req_r.retire_slot),
    .upd       (upd_gated),
    .head_live (head_live),
    .ret_live  (ret_live)
  );

  srsa_alloc u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .req       (req_r),
    .head_live (head_live),
    .ret_live  (ret_live),
    .head_idx  (head_idx),
    .upd       (upd),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full_r <= 1'b1;
      end else if (advance) begin
        in_full_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (advance) begin
      rsp_r <= rsp;
    end
  end

endmodule

`default_nettype wire
